// ----- hw/rtl/uipt_pkg.sv -----
// Shared constants, codes and types of the user ID and PIN table.
package uipt_pkg;

  // Table size and the number of characters that take part in matching.
  localparam int MAX_ENTRIES = 16;
  localparam int ID_CHARS    = 8;
  localparam int PIN_CHARS   = 5;

  // Field widths fixed by the request and result formats.
  localparam int ID_W          = 64;
  localparam int PIN_W         = 40;
  localparam int FUNC_W        = 3;
  localparam int CAT_W         = 2;
  localparam int STATUS_W      = 3;
  localparam int ENTRY_COUNT_W = 5;

  // Derived widths for the entry index and the fill count.
  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

  // Only the leading characters of the ID and of the PIN are compared.
  localparam int PIN_USED = (PIN_CHARS > 5) ? 5 : PIN_CHARS;
  localparam logic [ID_W-1:0] ID_MASK =
    ~((ID_W'(1) << (ID_W - 8 * ID_CHARS)) - ID_W'(1));
  localparam logic [PIN_W-1:0] PIN_MASK =
    ~((PIN_W'(1) << (PIN_W - 8 * PIN_USED)) - PIN_W'(1));

  // Request function codes.
  localparam logic [FUNC_W-1:0] FN_ADD    = 3'd0;
  localparam logic [FUNC_W-1:0] FN_DEL    = 3'd1;
  localparam logic [FUNC_W-1:0] FN_VERIFY = 3'd2;
  localparam logic [FUNC_W-1:0] FN_CHPIN  = 3'd3;
  localparam logic [FUNC_W-1:0] FN_RDCAT  = 3'd4;
  localparam logic [FUNC_W-1:0] FN_CHCAT  = 3'd5;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_IN_USE    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_PIN_WRONG = 3'd4;
  localparam logic [STATUS_W-1:0] ST_REFUSED   = 3'd5;

  // User categories; the unused code counts as basic.
  localparam logic [CAT_W-1:0] CAT_MASTER = 2'd0;
  localparam logic [CAT_W-1:0] CAT_ADMIN  = 2'd1;
  localparam logic [CAT_W-1:0] CAT_BASIC  = 2'd2;
  localparam logic [CAT_W-1:0] CAT_SPARE  = 2'd3;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [ID_W-1:0]   user_id;
    logic [PIN_W-1:0]  pin;
    logic [CAT_W-1:0]  category;
  } uipt_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic [CAT_W-1:0]         found_category;
    logic [ENTRY_COUNT_W-1:0] entry_count;
  } uipt_rsp_t;

  // One stored user record.
  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [PIN_W-1:0] pin;
    logic [CAT_W-1:0] cat;
  } uipt_rec_t;

  // Write port of the record memory.
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    uipt_rec_t        data;
  } uipt_wr_t;

endpackage

// ----- hw/rtl/uipt_ram.sv -----
// Record memory: one write port and one read port with registered read data.
module uipt_ram import uipt_pkg::*; (
  input  logic             clk,
  input  logic [IDX_W-1:0] rd_addr,
  output uipt_rec_t        rd_data,
  input  uipt_wr_t         wr_req
);

  uipt_rec_t rec_mem [MAX_ENTRIES];
  uipt_rec_t rd_data_r;

  // Write the addressed record and read one record every cycle.
  always_ff @(posedge clk) begin
    if (wr_req.en) begin
      rec_mem[wr_req.addr] <= wr_req.data;
    end
    rd_data_r <= rec_mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ----- hw/rtl/uipt_ctrl.sv -----
// Request sequencer: linear search over the record memory, then read-modify-write.
module uipt_ctrl import uipt_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  uipt_req_t        in_req,
  output logic             out_valid,
  output uipt_rsp_t        out_rsp,
  output logic [IDX_W-1:0] rd_addr,
  input  uipt_rec_t        rd_data,
  output uipt_wr_t         wr_req
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_EXEC,
    S_DEL_RD,
    S_DEL_WR
  } state_t;

  state_t           state_r, state_nxt;
  uipt_req_t        req_r, req_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             found_r, found_nxt;
  uipt_rec_t        frec_r, frec_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  uipt_rsp_t        rsp_r, rsp_nxt;

  logic [CAT_W-1:0] req_cat;
  logic             id_hit;
  logic             table_full;

  // The spare category code is stored as basic.
  assign req_cat    = (req_r.category == CAT_SPARE) ? CAT_BASIC : req_r.category;
  assign id_hit     = ((rd_data.id ^ req_r.user_id) & ID_MASK) == '0;
  assign table_full = cnt_r == CNT_W'(MAX_ENTRIES);

  // Next state, memory accesses and the result of each request.
  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    idx_nxt       = idx_r;
    found_nxt     = found_r;
    frec_nxt      = frec_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = 1'b0;
    rsp_nxt       = rsp_r;
    rd_addr       = idx_r;
    wr_req        = '0;

    unique case (state_r)
      S_IDLE: begin
        // Entry zero is fetched while the request is taken.
        rd_addr = '0;
        if (start) begin
          req_nxt   = in_req;
          idx_nxt   = '0;
          found_nxt = 1'b0;
          state_nxt = (cnt_r == '0) ? S_EXEC : S_SEARCH;
        end
      end

      S_SEARCH: begin
        // The data on hand belongs to idx_r; the next entry is already requested.
        rd_addr = IDX_W'(idx_r + 1'b1);
        if (id_hit) begin
          found_nxt = 1'b1;
          frec_nxt  = rd_data;
          state_nxt = S_EXEC;
        end else if ((CNT_W'(idx_r) + CNT_W'(1)) < cnt_r) begin
          idx_nxt = IDX_W'(idx_r + 1'b1);
        end else begin
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        out_valid_nxt          = 1'b1;
        state_nxt              = S_IDLE;
        rsp_nxt.status         = ST_OK;
        rsp_nxt.found_category = CAT_MASTER;
        unique case (req_r.func)
          FN_ADD: begin
            if (table_full) begin
              rsp_nxt.status = ST_FULL;
            end else if (found_r) begin
              rsp_nxt.status         = ST_IN_USE;
              rsp_nxt.found_category = frec_r.cat;
            end else begin
              wr_req.en              = 1'b1;
              wr_req.addr            = IDX_W'(cnt_r);
              wr_req.data.id         = req_r.user_id;
              wr_req.data.pin        = req_r.pin;
              wr_req.data.cat        = req_cat;
              cnt_nxt                = cnt_r + 1'b1;
              rsp_nxt.found_category = req_cat;
            end
          end
          FN_DEL: begin
            if (!found_r) begin
              rsp_nxt.status = ST_NOT_FOUND;
            end else begin
              // Fetch the last record to move it into the freed slot.
              out_valid_nxt = 1'b0;
              state_nxt     = S_DEL_RD;
            end
          end
          FN_VERIFY: begin
            if (!found_r) begin
              rsp_nxt.status = ST_NOT_FOUND;
            end else begin
              rsp_nxt.found_category = frec_r.cat;
              if (((frec_r.pin ^ req_r.pin) & PIN_MASK) != '0) begin
                rsp_nxt.status = ST_PIN_WRONG;
              end
            end
          end
          FN_CHPIN: begin
            if (!found_r) begin
              rsp_nxt.status = ST_NOT_FOUND;
            end else begin
              wr_req.en              = 1'b1;
              wr_req.addr            = idx_r;
              wr_req.data            = frec_r;
              wr_req.data.pin        = req_r.pin;
              rsp_nxt.found_category = frec_r.cat;
            end
          end
          FN_RDCAT: begin
            if (!found_r) begin
              rsp_nxt.status = ST_NOT_FOUND;
            end else begin
              rsp_nxt.found_category = frec_r.cat;
            end
          end
          FN_CHCAT: begin
            if (!found_r) begin
              rsp_nxt.status = ST_NOT_FOUND;
            end else if (frec_r.cat == CAT_MASTER && req_cat != CAT_MASTER) begin
              // A master may not be demoted.
              rsp_nxt.status = ST_REFUSED;
            end else begin
              wr_req.en              = 1'b1;
              wr_req.addr            = idx_r;
              wr_req.data            = frec_r;
              wr_req.data.cat        = req_cat;
              rsp_nxt.found_category = req_cat;
            end
          end
          default: begin
            rsp_nxt.status = ST_REFUSED;
          end
        endcase
        rsp_nxt.entry_count = ENTRY_COUNT_W'(cnt_nxt);
      end

      S_DEL_RD: begin
        rd_addr   = IDX_W'(cnt_r - 1'b1);
        state_nxt = S_DEL_WR;
      end

      S_DEL_WR: begin
        // The last record overwrites the deleted one.
        wr_req.en              = 1'b1;
        wr_req.addr            = idx_r;
        wr_req.data            = rd_data;
        cnt_nxt                = cnt_r - 1'b1;
        rsp_nxt.status         = ST_OK;
        rsp_nxt.found_category = frec_r.cat;
        rsp_nxt.entry_count    = ENTRY_COUNT_W'(cnt_nxt);
        out_valid_nxt          = 1'b1;
        state_nxt              = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State, fill count and registered result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
      req_r       <= req_nxt;
      idx_r       <= idx_nxt;
      frec_r      <= frec_nxt;
      rsp_r       <= rsp_nxt;
    end
  end

  assign busy      = state_r != S_IDLE;
  assign out_valid = out_valid_r;
  assign out_rsp   = rsp_r;

`ifndef NO_ASSERTIONS
  // The fill count never passes the table size.
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_ENTRIES))
    else $error("fill count above table size");

  // A result only follows work done in a busy state.
  a_rsp_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == S_EXEC || state_r == S_DEL_WR))
    else $error("result without a finished request");

  // Each request gives one result strobe, never two in a row.
  a_single_rsp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe longer than one cycle");

  // The memory is never written while idle.
  a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    wr_req.en |-> (state_r == S_EXEC || state_r == S_DEL_WR))
    else $error("memory write outside a request");

  // The search only visits stored entries.
  a_search_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SEARCH |-> CNT_W'(idx_r) < cnt_r)
    else $error("search index beyond stored entries");
`endif

endmodule

// ----- hw/rtl/user_id_pin_table.sv -----
// Top level of the user ID and PIN table: sequencer plus record memory.
//
// Accepts one request when start is high and busy is low, and answers it with
// a single-cycle out_valid strobe that the receiver cannot hold off. A request
// first searches the stored users linearly by ID, stopping at the first match,
// and then executes in S_EXEC; delete then passes through S_DEL_RD and
// S_DEL_WR to fetch and move the last record. Busy falls in the cycle the
// result is shown. The search through the single-read-port record memory takes
// the largest part of a request. No clearing is needed after reset: the table
// starts empty and only the contents of stored entries are ever used.
module user_id_pin_table import uipt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  uipt_req_t in_req,
  output logic      out_valid,
  output uipt_rsp_t out_rsp
);

  logic [IDX_W-1:0] rd_addr;
  uipt_rec_t        rd_data;
  uipt_wr_t         wr_req;

  // Request sequencer.
  uipt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_rsp   (out_rsp),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr_req    (wr_req)
  );

  // Record memory.
  uipt_ram u_ram (
    .clk     (clk),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_req  (wr_req)
  );

endmodule
